[rtl/sbsl_pkg.sv]
// Shared types and constants for the sparse bitmap stream loader.
package sbsl_pkg;

  // Bits covered by one node of the sparse bitmap.
  localparam int unsigned NODE_BITS = 64;
  localparam logic [31:0] NODE_BITS_W = 32'(NODE_BITS);
  localparam logic [31:0] ALIGN_MASK  = 32'(NODE_BITS - 1);

  // Result status codes.
  localparam logic [3:0] ST_NODE      = 4'd0;
  localparam logic [3:0] ST_DONE      = 4'd1;
  localparam logic [3:0] ST_BADSIZE   = 4'd2;
  localparam logic [3:0] ST_HIGHALIGN = 4'd3;
  localparam logic [3:0] ST_STARTALGN = 4'd4;
  localparam logic [3:0] ST_BEYOND    = 4'd5;
  localparam logic [3:0] ST_NULLMAP   = 4'd6;
  localparam logic [3:0] ST_ORDER     = 4'd7;
  localparam logic [3:0] ST_TRUNC     = 4'd8;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] start_bit;
    logic [63:0] node_map;
    logic [31:0] high_bit;
    logic [31:0] node_index;
  } sbsl_result_t;

endpackage

[rtl/sparse_bitmap_stream_loader_top.sv]
// Sparse bitmap stream loader: parses and checks header/node words; emits nodes and statuses.
// Results are registered: an accepted word's result (if any) enters the output register, or
//   the skid register while the output is stalled.
// Throughput: one word per cycle unless stalled; parser state updates when a word is taken.
// A two-entry result buffer (output register plus skid register) absorbs one result while the
//   result side stalls; in_stall is driven only by the skid register.
// Reset (rst_n low, synchronous): parser waits for the first header word, buffers empty.
module sparse_bitmap_stream_loader_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_start_bit,
  output logic [63:0] out_node_map,
  output logic [31:0] out_high_bit,
  output logic [31:0] out_node_index
);
  import sbsl_pkg::*;

  // Parser phases, in stream order.
  typedef enum logic [2:0] {
    PH_SIZE,   // waiting for map size word
    PH_HIGH,   // high bit word
    PH_COUNT,  // node count word; header checks happen here
    PH_START,  // node start bit
    PH_MAPLO,  // low word of node map
    PH_MAPHI,  // high word of node map; node is emitted here
    PH_DONE    // last node emitted, done pending on next word
  } phase_t;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic        size_ok_r, size_ok_nxt;
  logic [31:0] high_r, high_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] taken_r, taken_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] lo_r, lo_nxt;

  // Result buffer: main output register and skid register.
  logic         out_valid_r, out_valid_nxt;
  sbsl_result_t out_res_r, out_res_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  sbsl_result_t skid_res_r, skid_res_nxt;

  logic         accept;
  logic         produce;
  sbsl_result_t res;
  logic [31:0]  taken_inc;
  logic [63:0]  full_map;
  logic         take;

  // The skid register only fills while the output is stalled, so stalling on it
  // guarantees room for whatever the next word produces.
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign taken_inc = taken_r + 32'd1;
  assign full_map  = {in_data_word, lo_r};
  assign take      = out_valid_r && !out_stall;

  // Parser: one word in, at most one result out.
  always_comb begin
    phase_nxt     = phase_r;
    size_ok_nxt   = size_ok_r;
    high_nxt      = high_r;
    count_nxt     = count_r;
    taken_nxt     = taken_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    produce       = 1'b0;
    // Done and error results carry zero start and map; header and count as they stand.
    res.status     = ST_DONE;
    res.start_bit  = '0;
    res.node_map   = '0;
    res.high_bit   = high_r;
    res.node_index = taken_r;

    if (accept) begin
      if (phase_r == PH_DONE || phase_r == PH_SIZE) begin
        // Pending done goes out; the same word may open the next frame.
        produce   = (phase_r == PH_DONE);
        res.status = ST_DONE;
        phase_nxt = PH_SIZE;
        if (!in_stream_end) begin
          size_ok_nxt   = (in_data_word == NODE_BITS_W);
          high_nxt      = '0;
          count_nxt     = '0;
          taken_nxt     = '0;
          prev_nxt      = '0;
          have_prev_nxt = 1'b0;
          cur_nxt       = '0;
          lo_nxt        = '0;
          phase_nxt     = PH_HIGH;
        end
      end else if (in_stream_end) begin
        produce    = 1'b1;
        res.status = ST_TRUNC;
        phase_nxt  = PH_SIZE;
      end else begin
        case (phase_r)
          PH_HIGH: begin
            high_nxt  = in_data_word;
            phase_nxt = PH_COUNT;
          end
          PH_COUNT: begin
            count_nxt = in_data_word;
            phase_nxt = PH_SIZE;
            produce   = 1'b1;
            if (!size_ok_r) begin
              res.status = ST_BADSIZE;
            end else if (high_r == '0) begin
              res.status = ST_DONE;
            end else if ((high_r & ALIGN_MASK) != '0) begin
              res.status = ST_HIGHALIGN;
            end else if (in_data_word == '0) begin
              res.status = ST_DONE;
            end else begin
              produce   = 1'b0;
              phase_nxt = PH_START;
            end
          end
          PH_START: begin
            produce   = 1'b1;
            phase_nxt = PH_SIZE;
            if ((in_data_word & ALIGN_MASK) != '0) begin
              res.status = ST_STARTALGN;
            end else if (in_data_word > (high_r - NODE_BITS_W)) begin
              res.status = ST_BEYOND;  // high minus node size wraps as in 32-bit arithmetic
            end else begin
              produce   = 1'b0;
              cur_nxt   = in_data_word;
              phase_nxt = PH_MAPLO;
            end
          end
          PH_MAPLO: begin
            lo_nxt    = in_data_word;
            phase_nxt = PH_MAPHI;
          end
          PH_MAPHI: begin
            produce = 1'b1;
            if (full_map == '0) begin
              res.status = ST_NULLMAP;
              phase_nxt  = PH_SIZE;
            end else if (have_prev_r && (cur_r <= prev_r)) begin
              res.status = ST_ORDER;
              phase_nxt  = PH_SIZE;
            end else begin
              res.status    = ST_NODE;
              res.start_bit = cur_r;
              res.node_map  = full_map;
              prev_nxt      = cur_r;
              have_prev_nxt = 1'b1;
              taken_nxt     = taken_inc;
              phase_nxt     = (taken_inc >= count_r) ? PH_DONE : PH_START;
            end
          end
          default: begin
            phase_nxt = PH_SIZE;
          end
        endcase
      end
    end
  end

  // Result buffer steering.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        // No word is accepted while the skid is full, so nothing new arrives here.
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = produce;
        out_res_nxt   = res;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      size_ok_r    <= 1'b0;
      high_r       <= '0;
      count_r      <= '0;
      taken_r      <= '0;
      prev_r       <= '0;
      have_prev_r  <= 1'b0;
      cur_r        <= '0;
      lo_r         <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      size_ok_r    <= size_ok_nxt;
      high_r       <= high_nxt;
      count_r      <= count_nxt;
      taken_r      <= taken_nxt;
      prev_r       <= prev_nxt;
      have_prev_r  <= have_prev_nxt;
      cur_r        <= cur_nxt;
      lo_r         <= lo_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_start_bit  = out_res_r.start_bit;
  assign out_node_map   = out_res_r.node_map;
  assign out_high_bit   = out_res_r.high_bit;
  assign out_node_index = out_res_r.node_index;

  // Skid only ever backs up a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // Done is only pending after at least the declared number of nodes.
  a_done_after_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (have_prev_r && (taken_r >= count_r)))
    else $error("done pending without all nodes taken");

  // An emitted node never carries an empty map.
  a_node_map_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == ST_NODE)) |-> (out_res_r.node_map != '0))
    else $error("node result with zero map");

  // Node count and previous-start flag move together.
  a_prev_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    !have_prev_r |-> (taken_r == '0))
    else $error("nodes counted without a previous start");

endmodule
